// ===== design/clp_pkg.sv =====
// Shared constants, byte classification type and decode function for the char literal parser.
package clp_pkg;

  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_UC_C   = 8'h43;
  localparam logic [7:0] CH_UC_H   = 8'h48;
  localparam logic [7:0] CH_UC_A   = 8'h41;
  localparam logic [7:0] CH_UC_R   = 8'h52;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;

  // Width of the packed result beat: ok, char_value and consumed, padded to bytes.
  localparam int unsigned OutDataW = 16;
  localparam int unsigned CountW   = 4;

  typedef struct packed {
    logic       is_hex;
    logic [3:0] hex_nib;
    logic       is_esc;
    logic [7:0] esc_code;
  } clp_class_t;

  function automatic clp_class_t clp_classify(input logic [7:0] b);
    clp_class_t c;
    c = '0;
    if (b >= 8'h30 && b <= 8'h39) begin
      c.is_hex  = 1'b1;
      c.hex_nib = 4'(b - 8'h30);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      c.is_hex  = 1'b1;
      c.hex_nib = 4'(b - 8'h61 + 8'd10);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      c.is_hex  = 1'b1;
      c.hex_nib = 4'(b - 8'h41 + 8'd10);
    end
    case (b)
      CH_DOLLAR: begin c.is_esc = 1'b1; c.esc_code = CH_DOLLAR; end
      CH_QUOTE:  begin c.is_esc = 1'b1; c.esc_code = CH_QUOTE;  end
      8'h4E, 8'h6E, 8'h4C, 8'h6C: begin c.is_esc = 1'b1; c.esc_code = CH_NL; end
      8'h50, 8'h70: begin c.is_esc = 1'b1; c.esc_code = CH_FF;  end
      8'h52, 8'h72: begin c.is_esc = 1'b1; c.esc_code = CH_CR;  end
      8'h54, 8'h74: begin c.is_esc = 1'b1; c.esc_code = CH_TAB; end
      default: c.is_esc = 1'b0;
    endcase
    return c;
  endfunction

endpackage

// ===== design/clp_class.sv =====
// Byte classifier: hex digit value and escape letter code for one text byte.
module clp_class
  import clp_pkg::*;
(
  input  logic [7:0] byte_i,
  output clp_class_t class_o
);

  assign class_o = clp_classify(byte_i);

endmodule

// ===== design/char_literal_parser_unit.sv =====
// Character literal parser: streams a CHAR literal one byte per beat and emits its decoded value.
// A deciding byte passes through the input register, then the parse step into the output
// register, which holds its result beat.
// Throughput: one byte per cycle; the parse step is a single short transition of the
// phase register, so an input beat can enter every cycle while the output side takes beats.
// Reset (rst_ni low, asynchronous): both stages empty, phase set to done so bytes are
// ignored until one flagged first, held value and byte count cleared.
module char_literal_parser_unit
  import clp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // Input beats.
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [7:0]          s_axis_tdata_i,   // [7:0] text_byte
  input  logic [0:0]          s_axis_tuser_i,   // [0] first
  // Result beats.
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [OutDataW-1:0] m_axis_tdata_o    // [0] ok, [8:1] char_value,
                                                // [12:9] consumed, [15:13] zero
);

  // Parse position. The five prefix phases follow the leading 'C'.
  typedef enum logic [3:0] {
    PH_DONE      = 4'd0,
    PH_LEAD      = 4'd1,
    PH_PRE_H     = 4'd2,
    PH_PRE_A     = 4'd3,
    PH_PRE_R     = 4'd4,
    PH_PRE_HASH  = 4'd5,
    PH_PRE_QUOTE = 4'd6,
    PH_BODY      = 4'd7,
    PH_PLAIN     = 4'd8,
    PH_ESC1      = 4'd9,
    PH_ESC_CLOSE = 4'd10,
    PH_HEX2      = 4'd11,
    PH_HEX_CLOSE = 4'd12
  } phase_e;

  // Input register stage.
  logic              in_valid_q;
  logic [7:0]        byte_q;
  logic              first_q;

  // Parser state.
  phase_e            phase_q, phase_d;
  logic [7:0]        held_q, held_d;
  logic [CountW-1:0] count_q, count_d;

  // Output register stage.
  logic              out_valid_q;
  logic              out_ok_q;
  logic [7:0]        out_value_q;
  logic [CountW-1:0] out_count_q;

  logic              advance;
  logic              emit;
  logic              emit_ok;
  logic              out_load;
  clp_class_t        cls;

  // Effective state after a possible restart on a byte flagged first.
  phase_e            ph;
  logic [7:0]        held;
  logic [CountW-1:0] cnt;
  logic [CountW-1:0] cnt_inc;

  clp_class u_class (
    .byte_i  (byte_q),
    .class_o (cls)
  );

  // The held byte moves on whenever the output register is free or being drained,
  // so both sides keep one beat per cycle.
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign out_load        = advance && emit;

  always_comb begin
    ph      = first_q ? PH_LEAD : phase_q;
    held    = first_q ? 8'h00 : held_q;
    cnt     = first_q ? '0 : count_q;
    cnt_inc = cnt + CountW'(1);

    phase_d = ph;
    held_d  = held;
    count_d = (ph == PH_DONE) ? cnt : cnt_inc;
    emit    = 1'b0;
    emit_ok = 1'b0;

    case (ph)
      PH_DONE: begin
        emit = 1'b0;
      end
      PH_LEAD: begin
        if (byte_q == CH_QUOTE) begin
          phase_d = PH_BODY;
        end else if (byte_q == CH_UC_C) begin
          phase_d = PH_PRE_H;
        end else begin
          emit = 1'b1;
        end
      end
      PH_PRE_H: begin
        if (byte_q == CH_UC_H) phase_d = PH_PRE_A;
        else emit = 1'b1;
      end
      PH_PRE_A: begin
        if (byte_q == CH_UC_A) phase_d = PH_PRE_R;
        else emit = 1'b1;
      end
      PH_PRE_R: begin
        if (byte_q == CH_UC_R) phase_d = PH_PRE_HASH;
        else emit = 1'b1;
      end
      PH_PRE_HASH: begin
        if (byte_q == CH_HASH) phase_d = PH_PRE_QUOTE;
        else emit = 1'b1;
      end
      PH_PRE_QUOTE: begin
        if (byte_q == CH_QUOTE) phase_d = PH_BODY;
        else emit = 1'b1;
      end
      PH_BODY: begin
        if (byte_q == CH_QUOTE) begin
          // Empty body: the literal stands for code zero.
          emit    = 1'b1;
          emit_ok = 1'b1;
        end else if (byte_q == CH_DOLLAR) begin
          phase_d = PH_ESC1;
        end else begin
          held_d  = byte_q;
          phase_d = PH_PLAIN;
        end
      end
      PH_ESC1: begin
        // Escape letters win over hex digits where both could match.
        if (cls.is_esc) begin
          held_d  = cls.esc_code;
          phase_d = PH_ESC_CLOSE;
        end else if (cls.is_hex) begin
          held_d  = {cls.hex_nib, 4'h0};
          phase_d = PH_HEX2;
        end else begin
          emit = 1'b1;
        end
      end
      PH_HEX2: begin
        if (cls.is_hex) begin
          held_d  = {held[7:4], cls.hex_nib};
          phase_d = PH_HEX_CLOSE;
        end else begin
          emit = 1'b1;
        end
      end
      PH_PLAIN, PH_ESC_CLOSE, PH_HEX_CLOSE: begin
        emit    = 1'b1;
        emit_ok = (byte_q == CH_QUOTE);
      end
      default: begin
        // Unused codes behave as done.
        phase_d = ph;
        count_d = cnt;
      end
    endcase

    if (emit) phase_d = PH_DONE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      byte_q      <= 8'h00;
      first_q     <= 1'b0;
      phase_q     <= PH_DONE;
      held_q      <= 8'h00;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      out_ok_q    <= 1'b0;
      out_value_q <= 8'h00;
      out_count_q <= '0;
    end else begin
      if (s_axis_tready_o) begin
        in_valid_q <= s_axis_tvalid_i;
        byte_q     <= s_axis_tdata_i;
        first_q    <= s_axis_tuser_i[0];
      end
      if (advance) begin
        phase_q <= phase_d;
        held_q  <= held_d;
        count_q <= count_d;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
        out_ok_q    <= emit_ok;
        out_value_q <= emit_ok ? held : 8'h00;
        out_count_q <= emit_ok ? count_d : '0;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OutDataW - 1 - 8 - CountW){1'b0}},
                            out_count_q, out_value_q, out_ok_q};

  // A result must never overwrite one that is still waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || m_axis_tready_i))
    else $error("result register overwritten while stalled");

  // A failed literal carries zero value and zero count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ok_q) |-> (out_value_q == 8'h00 && out_count_q == '0))
    else $error("error beat carries a nonzero payload");

  // An accepted literal spans from two to ten bytes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_ok_q) |-> (out_count_q >= CountW'(2) && out_count_q <= CountW'(10)))
    else $error("accepted literal with impossible byte count");

  // The parser never leaves its defined phases.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q <= PH_HEX_CLOSE)
    else $error("parse phase out of range");

  // Once done, state moves only on a byte flagged first.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && phase_q == PH_DONE && !first_q) |=> (phase_q == PH_DONE && !$past(emit)))
    else $error("idle parser reacted to a byte");

endmodule

// ===== test/tb_char_literal_parser_unit.sv =====
// Self-checking testbench for the char literal parser: random stream stimulus and scoreboard.
module tb_char_literal_parser_unit;
  import clp_pkg::*;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned RandomBeats = 260;
  localparam int unsigned SettleLen   = 16;
  localparam int unsigned LongHoldLen = 60;
  localparam int unsigned MaxReported = 10;

  // Parse position of the predictor, one code per byte of "CHAR#'" and per body step.
  typedef enum logic [3:0] {
    LIT_DONE      = 4'd0,
    LIT_LEAD      = 4'd1,
    LIT_PFX_H     = 4'd2,
    LIT_PFX_A     = 4'd3,
    LIT_PFX_R     = 4'd4,
    LIT_PFX_HASH  = 4'd5,
    LIT_PFX_QUOTE = 4'd6,
    LIT_BODY      = 4'd7,
    LIT_PLAIN     = 4'd8,
    LIT_ESC1      = 4'd9,
    LIT_ESC_CLOSE = 4'd10,
    LIT_HEX2      = 4'd11,
    LIT_HEX_CLOSE = 4'd12
  } lit_phase_e;

  typedef struct packed {
    logic       ok;
    logic [7:0] code;
    logic [3:0] used;
  } lit_result_t;

  typedef struct {
    logic [7:0] text;
    logic       first;
    bit         drain;   // marker: sender pauses until every result is back
  } text_beat_t;

  typedef logic [7:0] text_q_t[$];

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [7:0]          s_tdata = 8'h00;
  logic [0:0]          s_tuser = 1'b0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;

  text_beat_t  pend_q[$];
  lit_result_t want_q[$];

  lit_phase_e  lit_phase = LIT_DONE;
  logic [7:0]  lit_held = 8'h00;
  logic [3:0]  lit_count = 4'h0;

  int unsigned err_cnt = 0;
  int unsigned results_seen = 0;
  int unsigned cycle_cnt = 0;
  int unsigned real_beats = 0;
  int          tx_gap = 0;
  int          tx_burst = 0;
  int          rx_stall = 0;
  int          rx_burst = 0;

  char_literal_parser_unit DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic void note_error(input string msg);
    err_cnt++;
    if (err_cnt <= MaxReported) $display("%s", msg);
  endfunction

  // {valid, nibble}
  function automatic logic [4:0] hex_nibble(input logic [7:0] b);
    if (b >= "0" && b <= "9") return {1'b1, 4'(b - "0")};
    if (b >= "a" && b <= "f") return {1'b1, 4'(b - "a" + 10)};
    if (b >= "A" && b <= "F") return {1'b1, 4'(b - "A" + 10)};
    return 5'h00;
  endfunction

  // {valid, code} for the byte that follows a dollar.
  function automatic logic [8:0] escape_code(input logic [7:0] b);
    case (b)
      CH_DOLLAR, CH_QUOTE:  return {1'b1, b};
      "N", "n", "L", "l":   return {1'b1, CH_NL};
      "P", "p":             return {1'b1, CH_FF};
      "R", "r":             return {1'b1, CH_CR};
      "T", "t":             return {1'b1, CH_TAB};
      default:              return 9'h000;
    endcase
  endfunction

  function automatic void close_literal(input logic ok, input logic [7:0] code);
    lit_result_t r;
    r.ok   = ok;
    r.code = ok ? code : 8'h00;
    r.used = ok ? lit_count : 4'h0;
    want_q.push_back(r);
    lit_phase = LIT_DONE;
  endfunction

  // Advances the predicted parse state by one accepted byte.
  function automatic void track_byte(input logic [7:0] b, input logic first);
    logic [4:0] hx;
    logic [8:0] es;
    logic [7:0] pfx;
    if (first) begin
      lit_phase = LIT_LEAD;
      lit_held  = 8'h00;
      lit_count = 4'h0;
    end
    if (lit_phase == LIT_DONE) return;
    lit_count = 4'(lit_count + 1);
    hx = hex_nibble(b);
    es = escape_code(b);
    case (lit_phase)
      LIT_LEAD: begin
        if (b == CH_QUOTE) lit_phase = LIT_BODY;
        else if (b == CH_UC_C) lit_phase = LIT_PFX_H;
        else close_literal(1'b0, 8'h00);
      end
      LIT_PFX_H, LIT_PFX_A, LIT_PFX_R, LIT_PFX_HASH, LIT_PFX_QUOTE: begin
        case (lit_phase)
          LIT_PFX_H:    pfx = CH_UC_H;
          LIT_PFX_A:    pfx = CH_UC_A;
          LIT_PFX_R:    pfx = CH_UC_R;
          LIT_PFX_HASH: pfx = CH_HASH;
          default:      pfx = CH_QUOTE;
        endcase
        if (b != pfx) close_literal(1'b0, 8'h00);
        else if (lit_phase == LIT_PFX_QUOTE) lit_phase = LIT_BODY;
        else lit_phase = lit_phase_e'(lit_phase + 4'd1);
      end
      LIT_BODY: begin
        if (b == CH_QUOTE) close_literal(1'b1, 8'h00);
        else if (b == CH_DOLLAR) lit_phase = LIT_ESC1;
        else begin
          lit_held  = b;
          lit_phase = LIT_PLAIN;
        end
      end
      LIT_ESC1: begin
        if (es[8]) begin
          lit_held  = es[7:0];
          lit_phase = LIT_ESC_CLOSE;
        end else if (hx[4]) begin
          lit_held  = {hx[3:0], 4'h0};
          lit_phase = LIT_HEX2;
        end else begin
          close_literal(1'b0, 8'h00);
        end
      end
      LIT_HEX2: begin
        if (!hx[4]) close_literal(1'b0, 8'h00);
        else begin
          lit_held  = lit_held | {4'h0, hx[3:0]};
          lit_phase = LIT_HEX_CLOSE;
        end
      end
      // Plain char, named escape and hex escape all close on a quote.
      default: close_literal(b == CH_QUOTE, lit_held);
    endcase
  endfunction

  // Mostly back-to-back, some short gaps, a few long ones, and bursts with none.
  function automatic int pick_gap(inout int burst);
    int r;
    if (burst > 0) begin
      burst--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 8) begin
      burst = $urandom_range(10, 40);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic add_bytes(input text_q_t txt);
    text_beat_t bt;
    foreach (txt[i]) begin
      bt.text  = txt[i];
      bt.first = (i == 0);
      bt.drain = 1'b0;
      pend_q.push_back(bt);
    end
    real_beats += txt.size();
  endtask

  task automatic add_text(input string s);
    text_q_t txt;
    for (int i = 0; i < s.len(); i++) txt.push_back(s[i]);
    add_bytes(txt);
  endtask

  // Bytes without the first flag; after a decided literal these are ignored.
  task automatic add_junk(input string s);
    text_beat_t bt;
    for (int i = 0; i < s.len(); i++) begin
      bt.text  = s[i];
      bt.first = 1'b0;
      bt.drain = 1'b0;
      pend_q.push_back(bt);
    end
  endtask

  function automatic logic [7:0] pick_char(input string pool);
    return pool[$urandom_range(0, pool.len() - 1)];
  endfunction

  task automatic add_random_literal();
    text_q_t    txt;
    text_beat_t bt;
    int         kind;
    int         pos;
    logic [7:0] b;
    string      prefix;
    kind = $urandom_range(0, 99);
    // Pure noise: random bytes with random first flags.
    if (kind < 10) begin
      repeat ($urandom_range(1, 4)) begin
        bt.text  = 8'($urandom_range(0, 255));
        bt.first = 1'($urandom_range(0, 1));
        bt.drain = 1'b0;
        pend_q.push_back(bt);
      end
      return;
    end
    prefix = "CHAR#";
    if ($urandom_range(0, 3) == 0) begin
      for (int i = 0; i < prefix.len(); i++) txt.push_back(prefix[i]);
    end
    txt.push_back(CH_QUOTE);
    case ($urandom_range(0, 3))
      0: ;
      1: begin
        do b = 8'($urandom_range(0, 255)); while (b == CH_QUOTE || b == CH_DOLLAR);
        txt.push_back(b);
      end
      2: begin
        txt.push_back(CH_DOLLAR);
        txt.push_back(pick_char("$'NnLlPpRrTt"));
      end
      default: begin
        txt.push_back(CH_DOLLAR);
        txt.push_back(pick_char("0123456789abcdefABCDEF"));
        txt.push_back(pick_char("0123456789abcdefABCDEF"));
      end
    endcase
    txt.push_back(CH_QUOTE);
    // A share of the literals is broken: a byte replaced, a byte added, or the end cut off.
    if (kind < 32) begin
      pos = $urandom_range(0, txt.size() - 1);
      b = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 255))
                                      : pick_char("'$CHAR#0aFGnx");
      case ($urandom_range(0, 2))
        0: txt[pos] = b;
        1: txt.insert(pos, b);
        default: while (txt.size() > pos + 1) void'(txt.pop_back());
      endcase
    end
    add_bytes(txt);
    if ($urandom_range(0, 4) == 0) add_junk("'$A");
  endtask

  // Sender: offers the next pending byte and predicts each one as it is taken.
  always @(posedge clk_i or negedge rst_ni) begin : sender_proc
    logic       offer;
    text_beat_t nxt;
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
      s_tdata  <= 8'h00;
      s_tuser  <= 1'b0;
      tx_gap = 0;
    end else begin
      offer = s_tvalid;
      if (s_tvalid && s_tready) begin
        track_byte(s_tdata, s_tuser[0]);
        offer  = 1'b0;
        tx_gap = pick_gap(tx_burst);
      end
      if (!offer && pend_q.size() > 0) begin
        if (pend_q[0].drain) begin
          if (want_q.size() == 0) pend_q.delete(0);
        end else if (tx_gap > 0) begin
          tx_gap--;
        end else begin
          nxt = pend_q.pop_front();
          s_tdata <= nxt.text;
          s_tuser <= nxt.first;
          offer = 1'b1;
        end
      end
      s_tvalid <= offer;
    end
  end

  // Receiver: checks every result beat against the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin : receiver_proc
    lit_result_t exp_r;
    logic [OutDataW-1:0] got;
    if (!rst_ni) begin
      m_tready <= 1'b0;
      rx_stall = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        results_seen++;
        if (want_q.size() == 0) begin
          note_error($sformatf("unexpected result beat %h", got));
        end else begin
          exp_r = want_q.pop_front();
          if (got[0] !== exp_r.ok || got[8:1] !== exp_r.code ||
              got[12:9] !== exp_r.used || got[15:13] !== 3'b000) begin
            note_error($sformatf(
              {"result %0d: expected ok=%0b char=%h consumed=%0d, ",
               "got ok=%0b char=%h consumed=%0d pad=%b"},
              results_seen, exp_r.ok, exp_r.code, exp_r.used,
              got[0], got[8:1], got[12:9], got[15:13]));
          end
        end
        // One long hold so that the parser backs up and stalls its input.
        if (results_seen == 40) rx_stall = LongHoldLen;
        else rx_stall = pick_gap(rx_burst);
      end else if (rx_stall == 0 && $urandom_range(0, 15) == 0) begin
        rx_stall = $urandom_range(1, 3);
      end
      if (rx_stall > 0) begin
        rx_stall--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin : main_proc
    text_q_t    txt;
    text_beat_t pause;
    bit         paused;
    // Directed literals: every body form, each malformed case and the byte extremes.
    add_text("''");
    add_text("'A'");
    add_text("'$$'");
    add_text("'$''");
    add_text("'$N'");
    add_text("'$l'");
    add_text("'$p'");
    add_text("'$R'");
    add_text("'$t'");
    add_text("'$4a'");
    add_text("'$Fc'");
    add_text("CHAR#'z'");
    txt = '{CH_QUOTE, 8'h00, CH_QUOTE};
    add_bytes(txt);
    txt = '{CH_QUOTE, 8'hFF, CH_QUOTE};
    add_bytes(txt);
    add_text("x");
    add_text("CHX");
    add_text("'ab");
    add_text("'$G");
    add_text("'$a'");
    add_text("'$nx");
    add_text("'$1z");
    add_text("'$12x");
    add_junk("'A'");
    // A new first byte drops an unfinished literal, and so does a never-closed one.
    add_text("'$4");
    add_text("'Q'");
    add_text("CHAR");
    add_text("'$0A'");

    real_beats = 0;
    paused = 1'b0;
    while (real_beats < RandomBeats) begin
      add_random_literal();
      if (!paused && real_beats >= RandomBeats / 2) begin
        pause.text  = 8'h00;
        pause.first = 1'b0;
        pause.drain = 1'b1;
        pend_q.push_back(pause);
        paused = 1'b1;
      end
    end

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pend_q.size() > 0 || s_tvalid) @(posedge clk_i);
    while (want_q.size() > 0) @(posedge clk_i);
    repeat (SettleLen) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
